// ----- rtl/core/gpio_hold_blink_controller_core_assert.svh -----
// Assertion macros for the GPIO hold/blink controller core.
// Clocked on clk, disabled while rst_n is low; empty under SYNTHESIS.
`ifndef GPIO_HOLD_BLINK_CONTROLLER_CORE_ASSERT_SVH
`define GPIO_HOLD_BLINK_CONTROLLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GHBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GHBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GHBC_ASSERT_IMP(label, ante, cons, msg)
`define GHBC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ghbc_pkg.sv -----
// Shared types, codes and constants of the GPIO hold/blink controller.
// No dependencies.
`default_nettype none

package ghbc_pkg;

    localparam int PIN_ENTRIES_DEF = 8;
    localparam int WALK_MAX        = 8;
    localparam int APB_AW          = 6;
    localparam int APB_DW          = 64;

    localparam logic [3:0] ST_LOW   = 4'd0;
    localparam logic [3:0] ST_HIGH  = 4'd1;
    localparam logic [3:0] ST_BLINK = 4'd2;

    localparam logic [7:0] CNT_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        REG_PIN_COUNT,
        REG_PIN_IDS,
        REG_DIRECTION,
        REG_IN_RESET,
        REG_OUT_RESET,
        REG_BLINK_LIMITS
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_WALK
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] cmd_byte;
        logic [7:0] pin_levels;
        logic [3:0] read_len;
    } req_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       entry_valid;
        logic       drive_en;
        logic       drive_level;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic       last_level;
        logic [7:0] low_count;
        logic [7:0] high_count;
    } hold_t;

    typedef struct packed {
        logic       level;
        logic [3:0] mode;
        hold_t      hold;
        logic       is_out;
        logic       in_reset;
        logic       out_reset;
        logic [7:0] limit;
        logic [1:0] reset_level;
    } entry_in_t;

    typedef struct packed {
        hold_t      hold;
        logic [3:0] mode;
        logic [1:0] reset_level;
        logic [3:0] shown;
        logic       drive_en;
        logic       drive_level;
    } entry_out_t;

    function automatic logic [3:0] entry_id(logic [31:0] ids, logic [2:0] idx);
        return ids[{idx, 2'b00} +: 4];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ghbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ghbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ghbc_entry.sv -----
// Per-entry update: hold counters, mode, report nibble, reset level and pin drive.
// Depends on ghbc_pkg.
`default_nettype none

module ghbc_entry (
    input  wire ghbc_pkg::entry_in_t ein,
    output ghbc_pkg::entry_out_t     eout
);

    import ghbc_pkg::*;

    logic [7:0]  cnt;
    logic [7:0]  cnt_new;
    logic [10:0] limit_x5;
    logic [7:0]  thr;
    logic [3:0]  mode_new;
    logic [1:0]  rl_new;
    logic        den;
    logic        dlev;

    always_comb
    begin
        cnt = ein.level ? ein.hold.high_count : ein.hold.low_count;
        if (ein.hold.last_level != ein.level)
        begin
            cnt_new = '0;
        end
        else if (cnt != CNT_MAX)
        begin
            cnt_new = cnt + 8'd1;
        end
        else
        begin
            cnt_new = cnt;
        end

        limit_x5 = {3'b000, ein.limit} + {1'b0, ein.limit, 2'b00};
        thr      = ein.limit;
        mode_new = ein.mode;
        rl_new   = ein.reset_level;
        den      = 1'b0;
        dlev     = 1'b0;

        if (!ein.is_out)
        begin
            if (ein.in_reset && ein.level && (cnt_new > ein.limit))
            begin
                rl_new = ({3'b000, cnt_new} > limit_x5) ? 2'd2 : 2'd1;
            end
        end
        else
        begin
            if (ein.out_reset)
            begin
                mode_new = (ein.reset_level != 2'd0) ? ST_BLINK : ST_LOW;
            end
            if (mode_new == ST_LOW || mode_new == ST_HIGH)
            begin
                if (mode_new[0] != ein.level)
                begin
                    den  = 1'b1;
                    dlev = mode_new[0];
                end
            end
            else if (mode_new == ST_BLINK)
            begin
                if (ein.out_reset && ein.reset_level == 2'd1)
                begin
                    thr = limit_x5[7:0];
                end
                if (ein.limit != 8'd0 && cnt_new > thr)
                begin
                    den  = 1'b1;
                    dlev = ~ein.level;
                end
            end
        end

        eout.hold.last_level = ein.level;
        eout.hold.low_count  = ein.level ? ein.hold.low_count : cnt_new;
        eout.hold.high_count = ein.level ? cnt_new : ein.hold.high_count;
        eout.mode            = mode_new;
        eout.reset_level     = rl_new;
        eout.shown           = (ein.mode == ST_LOW || ein.mode == ST_HIGH)
                               ? {3'b000, ein.level} : ein.mode;
        eout.drive_en        = den;
        eout.drive_level     = dlev;
    end

endmodule

`default_nettype wire

// ----- rtl/core/gpio_hold_blink_controller_core.sv -----
// Top level of the GPIO hold/blink controller: APB registers, walk control,
// state RAMs. Depends on ghbc_pkg, ghbc_ram, ghbc_entry and the assert header.
//
// One request at a time. A write request is accepted, then the id search and
// the mode update load its single response. A poll request's acceptance
// issues the read of entry 0, and each later step updates one entry from the
// registered read of the mode and hold RAMs, writes it back and reads the next
// entry, so the walk runs at one entry per cycle while the response register
// is free. A poll that walks no entry gives no response and leaves the block
// idle. A full response register stalls both the write update and the walk.
// Per-entry valid bits make unwritten RAM entries read as their reset value,
// so no clearing pass follows reset.
`default_nettype none

`include "gpio_hold_blink_controller_core_assert.svh"

module gpio_hold_blink_controller_core #(
    parameter int PIN_ENTRIES = ghbc_pkg::PIN_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ghbc_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ghbc_pkg::APB_DW-1:0]    pwdata,
    output logic      [ghbc_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire ghbc_pkg::req_t                 req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output ghbc_pkg::rsp_t                      rsp
);

    import ghbc_pkg::*;

    localparam int IDX_W = (PIN_ENTRIES > 1) ? $clog2(PIN_ENTRIES) : 1;
    localparam logic [3:0] PIN_LIM =
        4'((PIN_ENTRIES < WALK_MAX) ? PIN_ENTRIES : WALK_MAX);

    logic [3:0]  pin_count_reg;
    logic [31:0] pin_ids_reg;
    logic [7:0]  dir_reg;
    logic [7:0]  irst_reg;
    logic [7:0]  orst_reg;
    logic [63:0] limits_reg;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    state_t      state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  lim_reg, lim_next;
    req_t        item_reg, item_next;
    logic [1:0]  reset_level_reg, reset_level_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        rsp_ld;

    logic [PIN_ENTRIES-1:0] mode_vld_reg;
    logic [PIN_ENTRIES-1:0] hold_vld_reg;
    logic        mode_hit_reg;
    logic        hold_hit_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             mode_we;
    logic [IDX_W-1:0] mode_waddr;
    logic [3:0]       mode_wdata;
    logic             hold_we;
    logic [3:0]       mode_q;
    hold_t            hold_q;

    logic [3:0]  lim_cfg;
    logic [3:0]  lim_poll;
    logic        out_free;
    logic [2:0]  cur;
    logic [3:0]  nxt_idx;
    logic        is_last;
    logic        hit_found;
    logic [2:0]  hit_idx;
    logic        stop;

    entry_in_t   ein;
    entry_out_t  eout;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_count_reg <= '0;
            pin_ids_reg   <= '0;
            dir_reg       <= '0;
            irst_reg      <= '0;
            orst_reg      <= '0;
            limits_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PIN_COUNT:    pin_count_reg <= pwdata[3:0];
                REG_PIN_IDS:      pin_ids_reg   <= pwdata[31:0];
                REG_DIRECTION:    dir_reg       <= pwdata[7:0];
                REG_IN_RESET:     irst_reg      <= pwdata[7:0];
                REG_OUT_RESET:    orst_reg      <= pwdata[7:0];
                REG_BLINK_LIMITS: limits_reg    <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PIN_COUNT:    prdata = {60'd0, pin_count_reg};
            REG_PIN_IDS:      prdata = {32'd0, pin_ids_reg};
            REG_DIRECTION:    prdata = {56'd0, dir_reg};
            REG_IN_RESET:     prdata = {56'd0, irst_reg};
            REG_OUT_RESET:    prdata = {56'd0, orst_reg};
            REG_BLINK_LIMITS: prdata = limits_reg;
            default:          prdata = '0;
        endcase
    end

    // Walk limits
    always_comb
    begin
        lim_cfg = pin_count_reg;
        if (lim_cfg > PIN_LIM)
        begin
            lim_cfg = PIN_LIM;
        end
        lim_poll = lim_cfg;
        if (lim_poll > req.read_len)
        begin
            lim_poll = req.read_len;
        end
    end

    // Write target search
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        stop      = 1'b0;
        for (int i = 0; i < WALK_MAX; i++)
        begin
            if (!hit_found && !stop)
            begin
                if (4'(i) >= lim_reg || entry_id(pin_ids_reg, 3'(i)) == 4'd0)
                begin
                    stop = 1'b1;
                end
                else if (entry_id(pin_ids_reg, 3'(i)) == item_reg.cmd_byte[7:4]
                         && dir_reg[i])
                begin
                    hit_found = 1'b1;
                    hit_idx   = 3'(i);
                end
            end
        end
    end

    // Entry under update
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign cur      = idx_reg[2:0];
    assign nxt_idx  = idx_reg + 4'd1;
    assign is_last  = (nxt_idx >= lim_reg) || (entry_id(pin_ids_reg, nxt_idx[2:0]) == 4'd0);

    always_comb
    begin
        ein.level       = item_reg.pin_levels[cur];
        ein.mode        = mode_hit_reg ? mode_q : ST_LOW;
        ein.hold        = hold_hit_reg ? hold_q : '0;
        ein.is_out      = dir_reg[cur];
        ein.in_reset    = irst_reg[cur];
        ein.out_reset   = orst_reg[cur];
        ein.limit       = limits_reg[{cur, 3'b000} +: 8];
        ein.reset_level = reset_level_reg;
    end

    ghbc_entry u_entry (
        .ein  (ein),
        .eout (eout)
    );

    ghbc_ram #(
        .WIDTH (4),
        .DEPTH (PIN_ENTRIES)
    ) u_mode_ram (
        .clk   (clk),
        .we    (mode_we),
        .waddr (mode_waddr),
        .wdata (mode_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mode_q)
    );

    ghbc_ram #(
        .WIDTH ($bits(hold_t)),
        .DEPTH (PIN_ENTRIES)
    ) u_hold_ram (
        .clk   (clk),
        .we    (hold_we),
        .waddr (IDX_W'(idx_reg)),
        .wdata (eout.hold),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (hold_q)
    );

    // Control
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        lim_next         = lim_reg;
        item_next        = item_reg;
        reset_level_next = reset_level_reg;
        rd_en            = 1'b0;
        rd_addr          = IDX_W'(idx_reg);
        mode_we          = 1'b0;
        mode_waddr       = IDX_W'(idx_reg);
        mode_wdata       = eout.mode;
        hold_we          = 1'b0;
        rsp_ld           = 1'b0;
        rsp_next         = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    idx_next  = '0;
                    if (!req.req_type)
                    begin
                        lim_next   = lim_cfg;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        lim_next = lim_poll;
                        if (lim_poll != 4'd0 && entry_id(pin_ids_reg, 3'd0) != 4'd0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    mode_we              = hit_found;
                    mode_waddr           = IDX_W'(hit_idx);
                    mode_wdata           = item_reg.cmd_byte[3:0];
                    rsp_ld               = 1'b1;
                    rsp_next.report_byte = '0;
                    rsp_next.entry_valid = hit_found;
                    rsp_next.drive_en    = 1'b0;
                    rsp_next.drive_level = 1'b0;
                    rsp_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    mode_we              = 1'b1;
                    hold_we              = 1'b1;
                    reset_level_next     = eout.reset_level;
                    rsp_ld               = 1'b1;
                    rsp_next.report_byte = {entry_id(pin_ids_reg, cur), eout.shown};
                    rsp_next.entry_valid = 1'b1;
                    rsp_next.drive_en    = eout.drive_en;
                    rsp_next.drive_level = eout.drive_level;
                    rsp_next.last        = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = nxt_idx;
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(nxt_idx);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_ld ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            lim_reg         <= '0;
            reset_level_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            mode_vld_reg    <= '0;
            hold_vld_reg    <= '0;
            mode_hit_reg    <= 1'b0;
            hold_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            lim_reg         <= lim_next;
            reset_level_reg <= reset_level_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (mode_we)
            begin
                mode_vld_reg[mode_waddr] <= 1'b1;
            end
            if (hold_we)
            begin
                hold_vld_reg[IDX_W'(idx_reg)] <= 1'b1;
            end
            if (rd_en)
            begin
                mode_hit_reg <= mode_vld_reg[rd_addr];
                hold_hit_reg <= hold_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (rsp_ld)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `GHBC_ASSERT_NXT(a_reset_level_sticky, reset_level_reg != 2'd0, reset_level_reg != 2'd0, "reset level dropped")
    `GHBC_ASSERT_IMP(a_walk_in_range, state_reg == S_WALK, idx_reg < lim_reg, "walk index past limit")
    `GHBC_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_reg), $past(state_reg) == S_WRITE || $past(state_reg) == S_WALK, "response without request")
    `GHBC_ASSERT_IMP(a_no_rw_overlap, rd_en && state_reg == S_WALK, rd_addr != IDX_W'(idx_reg), "read of entry under update")

endmodule

`default_nettype wire
